// ===== rtl/core/code_table_symbol_encoder_defines.svh =====
// ---------------------------------------------------------------------------
// code_table_symbol_encoder_defines
// Assertion macros used by the encoder top level.
// ---------------------------------------------------------------------------
`ifndef CODE_TABLE_SYMBOL_ENCODER_DEFINES_SVH
`define CODE_TABLE_SYMBOL_ENCODER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define CTSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define CTSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ctse_pkg.sv =====
// ---------------------------------------------------------------------------
// ctse_pkg
// Types, codes and helper functions of the code table symbol encoder.
// ---------------------------------------------------------------------------
package ctse_pkg;

  localparam int DEF_TABLE_DEPTH  = 64;
  localparam int DEF_MAX_CODE_LEN = 32;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

  // Result status
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Characters remapped before lookup
  localparam logic [SYM_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [SYM_W-1:0] CH_DASH    = 8'h2D;
  localparam logic [SYM_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [SYM_W-1:0] CH_BANG    = 8'h21;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
    logic              last;
    logic [STAT_W-1:0] status;
  } result_t;

  // Mask of the low len bits, all ones from the full code width up
  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    if (len >= LEN_W'(CODE_W)) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << len) - CODE_W'(1);
    end
    return m;
  endfunction

  // Map space to dash and newline to bang
  function automatic logic [SYM_W-1:0] map_sym(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] r;
    if (s == CH_SPACE) begin
      r = CH_DASH;
    end else if (s == CH_NEWLINE) begin
      r = CH_BANG;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/code_table_symbol_encoder.sv =====
// ---------------------------------------------------------------------------
// code_table_symbol_encoder
// Table driven variable-length code encoder with a loadable code table.
// ---------------------------------------------------------------------------
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+----------------------------------------
//   input   | in_valid_i  | in_stall_o  | cmd_i symbol_byte_i entry_code_i entry_len_i
//   output  | out_valid_o | out_stall_i | code_bits_o code_len_o last_o status_o
//
// An end on a loaded table first reads the last entry. An encode on a loaded
// table scans it one word per cycle, unless a stalled output holds a hit back,
// through the single read port of the table memory. Reset clears the entry count
// and the control state; the table keeps no valid bits, since only entries below
// the count are ever read. A stalled output pauses the scan on the next hit and
// holds off new input.
//
`include "code_table_symbol_encoder_defines.svh"

module code_table_symbol_encoder
  import ctse_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [SYM_W-1:0]  symbol_byte_i,
  input  logic [CODE_W-1:0] entry_code_i,
  input  logic [LEN_W-1:0]  entry_len_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CODE_W-1:0] code_bits_o,
  output logic [LEN_W-1:0]  code_len_o,
  output logic              last_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          out_ready;
  logic          push;
  result_t       push_res;
  result_t       out_res;

  ctse_table_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ctse_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .symbol_byte_i (symbol_byte_i),
    .entry_code_i  (entry_code_i),
    .entry_len_i   (entry_len_i),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_ready_i   (out_ready),
    .push_o        (push),
    .res_o         (push_res)
  );

  ctse_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (push_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign code_bits_o = out_res.code_bits;
  assign code_len_o  = out_res.code_len;
  assign last_o      = out_res.last;
  assign status_o    = out_res.status;

  // Checks
  `CTSE_ASSERT_NEXT(a_load_ack, in_valid_i && !in_stall_o && (cmd_i == CMD_LOAD), out_valid_o, "load transfer without acknowledgement")
  `CTSE_ASSERT_SAME(a_flag_shape, out_valid_o && (status_o != STAT_OK), last_o && (code_len_o == '0) && (code_bits_o == '0), "flagged result not an empty last result")
  `CTSE_ASSERT_SAME(a_mid_ok, out_valid_o && !last_o, status_o == STAT_OK, "non-final result carries a flag")

endmodule

// ===== rtl/core/ctse_table_mem.sv =====
// ---------------------------------------------------------------------------
// ctse_table_mem
// Code table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ctse_table_mem
  import ctse_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry, hold the data while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/ctse_out_buf.sv =====
// ---------------------------------------------------------------------------
// ctse_out_buf
// Output register of the result channel.
// ---------------------------------------------------------------------------
module ctse_out_buf
  import ctse_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Room when empty or when the held result transfers this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/ctse_seq.sv =====
// ---------------------------------------------------------------------------
// ctse_seq
// Command sequencer: table loads, the lookup scan and the terminator read.
// ---------------------------------------------------------------------------
module ctse_seq
  import ctse_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [SYM_W-1:0]  symbol_byte_i,
  input  logic [CODE_W-1:0] entry_code_i,
  input  logic [LEN_W-1:0]  entry_len_i,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output entry_t            wr_data_o,
  output logic              rd_en_o,
  output logic [AW-1:0]     rd_addr_o,
  input  entry_t            rd_data_i,
  input  logic              out_ready_i,
  output logic              push_o,
  output result_t           res_o
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LenLimit = LEN_W'(LEN_LIMIT);
  localparam logic [CW-1:0]    Depth    = CW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TERM = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    last_idx;
  logic             pend_q, pend_d;
  logic             hold_valid_q, hold_valid_d;
  entry_t           hold_q, hold_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic [LEN_W-1:0] sat_len;
  logic             accept;
  logic             match;
  logic             consume;
  logic             issue;

  assign in_stall_o = !((state_q == ST_IDLE) && out_ready_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign last_idx   = count_q - CW'(1);
  assign sat_len    = (entry_len_i > LenLimit) ? LenLimit : entry_len_i;
  assign match      = pend_q && (rd_data_i.sym == sym_q);

  // Next-state and datapath control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    sym_d        = sym_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = count_q[AW-1:0];
    wr_data_o    = '{sym: symbol_byte_i,
                     code: entry_code_i & low_mask(sat_len),
                     len: sat_len};
    rd_en_o      = 1'b0;
    rd_addr_o    = idx_q[AW-1:0];
    push_o       = 1'b0;
    res_o        = '{code_bits: '0, code_len: '0, last: 1'b1, status: STAT_OK};
    consume      = 1'b0;
    issue        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_LOAD: begin
              push_o = 1'b1;
              if (count_q < Depth) begin
                wr_en_o = 1'b1;
                count_d = count_q + CW'(1);
              end else begin
                res_o.status = STAT_FULL;
              end
            end
            CMD_ENCODE: begin
              sym_d        = map_sym(symbol_byte_i);
              idx_d        = '0;
              hold_valid_d = 1'b0;
              if (count_q != '0) begin
                state_d = ST_SCAN;
              end
            end
            CMD_END: begin
              if (count_q == '0) begin
                push_o       = 1'b1;
                res_o.status = STAT_EMPTY;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = last_idx[AW-1:0];
                pend_d    = 1'b1;
                state_d   = ST_TERM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Drop a miss at once; a hit waits until the held hit can move out
        consume = pend_q && (!match || !hold_valid_q || out_ready_i);
        if (match && hold_valid_q && out_ready_i) begin
          push_o          = 1'b1;
          res_o.code_bits = hold_q.code;
          res_o.code_len  = hold_q.len;
          res_o.last      = 1'b0;
        end
        if (consume && match) begin
          hold_d       = rd_data_i;
          hold_valid_d = 1'b1;
        end
        // Advance the read pointer when the read data slot frees up
        issue = (idx_q < count_q) && (!pend_q || consume);
        if (issue) begin
          rd_en_o = 1'b1;
          idx_d   = idx_q + CW'(1);
          pend_d  = 1'b1;
        end else if (consume) begin
          pend_d = 1'b0;
        end
        // Table exhausted: release the final hit marked last
        if (!pend_q && (idx_q == count_q)) begin
          if (hold_valid_q) begin
            if (out_ready_i) begin
              push_o          = 1'b1;
              res_o.code_bits = hold_q.code;
              res_o.code_len  = hold_q.len;
              hold_valid_d    = 1'b0;
              state_d         = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_TERM: begin
        if (out_ready_i) begin
          push_o          = 1'b1;
          res_o.code_bits = rd_data_i.code;
          res_o.code_len  = rd_data_i.len;
          pend_d          = 1'b0;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    sym_q  <= sym_d;
  end

endmodule

// ===== sim/tb_code_table_symbol_encoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_code_table_symbol_encoder
// Self-checking bench for the table driven code encoder. A queue of requests
// (table loads, message bytes, message ends and unused commands) feeds a
// clocked driver. Each accepted request runs through a local copy of the code
// table and queues the code words that it must produce. A clocked monitor
// checks every output transfer against the oldest queued code word. Both
// sides idle in random bursts, and the receiver holds off once for a long
// stretch so that the encoder backs up into its input.
// ---------------------------------------------------------------------------
module tb_code_table_symbol_encoder;
  import ctse_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LEN_CAP       = (DEF_MAX_CODE_LEN < CODE_W) ? DEF_MAX_CODE_LEN : CODE_W;
  localparam int ITEMS_TARGET  = 410;
  localparam int CALM_TAIL     = 60;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 2 * DEF_TABLE_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 3000000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } enc_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  cmd_i = CMD_LOAD;
  logic [SYM_W-1:0]  symbol_byte_i = '0;
  logic [CODE_W-1:0] entry_code_i = '0;
  logic [LEN_W-1:0]  entry_len_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CODE_W-1:0] code_bits_o;
  logic [LEN_W-1:0]  code_len_o;
  logic              last_o;
  logic [STAT_W-1:0] status_o;

  // Stimulus and expectations
  enc_req_t         pending_reqs[$];
  enc_req_t         cur_req;
  result_t          pending_codewords[$];
  logic [SYM_W-1:0] gen_syms[$];
  int               total_reqs = 0;
  int               accepted_cnt = 0;
  int               gap_left = 0;
  int               hold_left = 0;
  logic             hold_done = 1'b0;
  int               cycle_cnt = 0;

  // Local copy of the code table
  logic [SYM_W-1:0]  tbl_sym [DEF_TABLE_DEPTH];
  logic [CODE_W-1:0] tbl_code[DEF_TABLE_DEPTH];
  logic [LEN_W-1:0]  tbl_len [DEF_TABLE_DEPTH];
  int                tbl_count = 0;

  // Statistics
  int n_load = 0, n_full = 0, n_encode = 0, n_end = 0, n_hits = 0;
  int n_checked = 0, mismatches = 0;

  wire calm = (accepted_cnt + CALM_TAIL >= total_reqs);

  code_table_symbol_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .symbol_byte_i (symbol_byte_i),
    .entry_code_i  (entry_code_i),
    .entry_len_i   (entry_len_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_bits_o   (code_bits_o),
    .code_len_o    (code_len_o),
    .last_o        (last_o),
    .status_o      (status_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Work out the code words one accepted request produces
  function automatic void predict_codewords(input enc_req_t r);
    result_t          res;
    result_t          hits[$];
    logic [SYM_W-1:0] key;
    logic [LEN_W-1:0] l;
    logic [CODE_W-1:0] mask;
    res = '0;
    res.last = 1'b1;
    res.status = STAT_OK;
    case (r.cmd)
      CMD_LOAD: begin
        n_load++;
        if (tbl_count >= DEF_TABLE_DEPTH) begin
          n_full++;
          res.status = STAT_FULL;
        end else begin
          // Clamp the length, drop code bits above it
          l = (r.len > LEN_CAP) ? LEN_W'(LEN_CAP) : r.len;
          mask = (l >= CODE_W) ? {CODE_W{1'b1}} : ((CODE_W'(1) << l) - CODE_W'(1));
          tbl_sym[tbl_count] = r.sym;
          tbl_code[tbl_count] = r.code & mask;
          tbl_len[tbl_count] = l;
          tbl_count++;
        end
        pending_codewords = {pending_codewords, res};
      end
      CMD_ENCODE: begin
        n_encode++;
        key = r.sym;
        if (key == CH_SPACE) begin
          key = CH_DASH;
        end else if (key == CH_NEWLINE) begin
          key = CH_BANG;
        end
        // Scan in table order, mark only the final hit as last
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_sym[i] == key) begin
            res.code_bits = tbl_code[i];
            res.code_len = tbl_len[i];
            res.last = 1'b0;
            hits = {hits, res};
          end
        end
        if (hits.size() != 0) begin
          hits[hits.size()-1].last = 1'b1;
        end
        n_hits += hits.size();
        pending_codewords = {pending_codewords, hits};
      end
      CMD_END: begin
        n_end++;
        if (tbl_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.code_bits = tbl_code[tbl_count-1];
          res.code_len = tbl_len[tbl_count-1];
        end
        pending_codewords = {pending_codewords, res};
      end
      default: begin
      end
    endcase
  endfunction

  // Queue one request and track the symbols the table will hold
  function automatic void queue_req(input logic [CMD_W-1:0] c, input logic [SYM_W-1:0] s,
                                    input logic [CODE_W-1:0] k, input logic [LEN_W-1:0] l);
    enc_req_t r;
    r.cmd = c;
    r.sym = s;
    r.code = k;
    r.len = l;
    pending_reqs = {pending_reqs, r};
    if (c == CMD_LOAD && gen_syms.size() < DEF_TABLE_DEPTH) begin
      gen_syms = {gen_syms, s};
    end
  endfunction

  // Pick a message byte, mostly one the table knows
  function automatic logic [SYM_W-1:0] pick_msg_byte();
    logic [SYM_W-1:0] s;
    if (gen_syms.size() == 0 || $urandom_range(0, 4) == 0) begin
      s = SYM_W'($urandom_range(0, 255));
    end else begin
      s = gen_syms[$urandom_range(0, gen_syms.size() - 1)];
      if (s == CH_DASH && $urandom_range(0, 1) == 1) begin
        s = CH_SPACE;
      end else if (s == CH_BANG && $urandom_range(0, 1) == 1) begin
        s = CH_NEWLINE;
      end
    end
    return s;
  endfunction

  // Build the stimulus, reset, then wait for the last code word
  initial begin
    int n_items;
    int n_msg;
    int n_ld;
    logic [SYM_W-1:0] s;
    logic [LEN_W-1:0] l;

    // Empty table: flagged end, silent encode, ignored command
    queue_req(CMD_END, 8'h41, 32'h0, 6'd1);
    queue_req(CMD_ENCODE, 8'h41, 32'h0, 6'd0);
    queue_req(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    // Loads at the length extremes, remapped targets and duplicates
    queue_req(CMD_LOAD, CH_DASH, 32'hFFFF_FFFF, 6'd0);
    queue_req(CMD_LOAD, CH_BANG, 32'h8000_0001, 6'd1);
    queue_req(CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    queue_req(CMD_LOAD, 8'hFF, 32'hDEAD_BEEF, 6'd63);
    queue_req(CMD_LOAD, 8'h41, 32'h0000_0005, 6'd3);
    queue_req(CMD_LOAD, 8'h41, 32'hFFFF_FFFF, 6'd33);
    queue_req(CMD_LOAD, CH_SPACE, 32'h0000_0003, 6'd2);
    // Encodes: remapped bytes, multiple hits, extremes, no hit
    queue_req(CMD_ENCODE, CH_SPACE, 32'h0, 6'd0);
    queue_req(CMD_ENCODE, CH_NEWLINE, 32'h0, 6'd0);
    queue_req(CMD_ENCODE, CH_DASH, 32'h0, 6'd0);
    queue_req(CMD_ENCODE, CH_BANG, 32'h0, 6'd0);
    queue_req(CMD_ENCODE, 8'h41, 32'h0, 6'd0);
    queue_req(CMD_ENCODE, 8'h00, 32'h0, 6'd0);
    queue_req(CMD_ENCODE, 8'hFF, 32'h0, 6'd0);
    queue_req(CMD_ENCODE, 8'h42, 32'h0, 6'd0);
    queue_req(CMD_END, 8'h00, 32'h0, 6'd0);
    queue_req(CMD_LOAD, 8'h41, 32'h0, 6'h20);
    queue_req(CMD_ENCODE, 8'h41, 32'h0, 6'd0);
    queue_req(CMD_END, 8'h00, 32'h0, 6'd0);
    n_items = 21;

    // Random messages: a few loads, a run of encodes, then an end
    while (n_items < ITEMS_TARGET) begin
      n_ld = (gen_syms.size() < DEF_TABLE_DEPTH) ? int'($urandom_range(0, 3))
                                                 : int'($urandom_range(0, 4) == 0);
      for (int k = 0; k < n_ld; k++) begin
        case ($urandom_range(0, 3))
          0: s = SYM_W'($urandom_range(0, 255));
          1: s = ($urandom_range(0, 1) == 1) ? CH_DASH : CH_BANG;
          default: s = 8'h61 + SYM_W'($urandom_range(0, 7));
        endcase
        l = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 63))
                                        : LEN_W'($urandom_range(1, 32));
        queue_req(CMD_LOAD, s, $urandom, l);
        n_items++;
      end
      n_msg = $urandom_range(1, 10);
      for (int k = 0; k < n_msg; k++) begin
        queue_req(CMD_ENCODE, pick_msg_byte(), $urandom, LEN_W'($urandom_range(0, 63)));
        n_items++;
      end
      // Leave a message unterminated now and then
      if ($urandom_range(0, 9) != 0) begin
        queue_req(CMD_END, SYM_W'($urandom_range(0, 255)), $urandom,
                  LEN_W'($urandom_range(0, 63)));
        n_items++;
      end
      if ($urandom_range(0, 7) == 0) begin
        queue_req(CMD_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
                  LEN_W'($urandom_range(0, 63)));
      end
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || pending_codewords.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d loads (%0d into a full table), %0d encodes (%0d hits), %0d ends",
             n_load, n_full, n_encode, n_hits, n_end);
    $display("checked %0d code words, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && pending_codewords.size() == 0) begin
      $display("tb_code_table_symbol_encoder: clean");
    end else begin
      $display("tb_code_table_symbol_encoder: errors");
    end
    $finish;
  end

  // Offer requests, predict on each transfer, idle in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_codewords(cur_req);
        accepted_cnt <= accepted_cnt + 1;
      end
      // Hold a stalled request; otherwise move on
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
          gap_left <= $urandom_range(0, 13);
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          cmd_i <= cur_req.cmd;
          symbol_byte_i <= cur_req.sym;
          entry_code_i <= cur_req.code;
          entry_len_i <= cur_req.len;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Drive output stall: random bursts plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each output transfer against the oldest expected code word
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (pending_codewords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected output: bits %h len %0d last %0d status %0d",
                   code_bits_o, code_len_o, last_o, status_o);
        end
      end else begin
        want = pending_codewords.pop_front();
        if (code_bits_o !== want.code_bits || code_len_o !== want.code_len ||
            last_o !== want.last || status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected bits %h len %0d last %0d status %0d",
                     want.code_bits, want.code_len, want.last, want.status);
            $display("          got      bits %h len %0d last %0d status %0d",
                     code_bits_o, code_len_o, last_o, status_o);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d code words still expected",
               cycle_cnt, pending_codewords.size());
      $display("tb_code_table_symbol_encoder: errors");
      $finish;
    end
  end

endmodule
